// ===== hdl/bqe_pkg.sv =====
// Shared constants, codes and control types of the biquad cascade equalizer.
package bqe_pkg;

  localparam int SECTIONS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;

  localparam int ACTION_W = 2;
  localparam int BAND_W   = 2;
  localparam int CIDX_W   = 3;

  // Coefficients per section, and the index of the last step of one section pass
  localparam int NCOEF     = 5;
  localparam int LAST_STEP = NCOEF + 1;
  localparam int STEP_W    = $clog2(LAST_STEP + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_FILTER = 2'd0,
    ACT_COEF   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [CIDX_W-1:0] COEF_B0 = 3'd0;
  localparam logic [CIDX_W-1:0] COEF_B1 = 3'd1;
  localparam logic [CIDX_W-1:0] COEF_B2 = 3'd2;
  localparam logic [CIDX_W-1:0] COEF_A1 = 3'd3;
  localparam logic [CIDX_W-1:0] COEF_A2 = 3'd4;

  // Control broadcast from the top level to every section cell
  typedef struct packed {
    logic                coef_wr;
    logic [BAND_W-1:0]   band;
    logic [CIDX_W-1:0]   coef_index;
    logic                clear;
  } cell_ctrl_t;

endpackage

// ===== hdl/bqe_if.sv =====
// Valid/ready channel interfaces for the equalizer's input and result items.
interface bqe_in_if #(
  parameter int SAMPLE_BITS = bqe_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqe_pkg::COEF_BITS_DEF
);
  import bqe_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [ACTION_W-1:0]           action;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [BAND_W-1:0]             band;
  logic [CIDX_W-1:0]             coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;

  modport source (output valid, action, sample_in, band, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, action, sample_in, band, coef_index, coef_value,
                  output ready);
endinterface

interface bqe_out_if #(
  parameter int SAMPLE_BITS = bqe_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ===== hdl/bqe_cell.sv =====
// One biquad section: coefficients, history and a serial multiply-accumulate.
module bqe_cell #(
  parameter int SAMPLE_BITS = bqe_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqe_pkg::COEF_BITS_DEF,
  parameter int CELL_ID     = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bqe_pkg::cell_ctrl_t           ctrl,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] y_out
);
  import bqe_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + 4;
  localparam int FRAC   = COEF_BITS - 4;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LAST_STEP);
  localparam logic [STEP_W-1:0] STEP_MAC  = STEP_W'(NCOEF);

  localparam logic signed [ACC_W-1:0] ROUND  = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SAMPLE_BITS+1){1'b0}},
                                                {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [COEF_BITS-1:0] UNITY = {{(COEF_BITS-1){1'b0}}, 1'b1} << FRAC;

  logic signed [COEF_BITS-1:0]   coef_r [NCOEF];
  logic signed [SAMPLE_BITS-1:0] x1_r, x2_r, y1_r, y2_r, xin_r, y_r;
  logic [STEP_W-1:0]             step_r;
  logic                          busy_r, done_r, sub_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic signed [COEF_BITS-1:0]   coef_sel;
  logic signed [SAMPLE_BITS-1:0] opnd_sel;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [ACC_W-1:0]       acc_nxt, shr;
  logic signed [SAMPLE_BITS-1:0] y_nxt;
  logic                          wr_here;

  assign wr_here = ctrl.coef_wr && (int'(ctrl.band) == CELL_ID);

  always_comb begin
    coef_sel = '0;
    opnd_sel = '0;
    case (step_r[CIDX_W-1:0])
      COEF_B0: begin coef_sel = coef_r[0]; opnd_sel = xin_r; end
      COEF_B1: begin coef_sel = coef_r[1]; opnd_sel = x1_r;  end
      COEF_B2: begin coef_sel = coef_r[2]; opnd_sel = x2_r;  end
      COEF_A1: begin coef_sel = coef_r[3]; opnd_sel = y1_r;  end
      COEF_A2: begin coef_sel = coef_r[4]; opnd_sel = y2_r;  end
      default: begin coef_sel = '0;        opnd_sel = '0;    end
    endcase
  end

  assign prod_nxt = coef_sel * opnd_sel;

  // Feedback terms enter with a minus sign
  assign acc_nxt = sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  assign shr = acc_r >>> FRAC;

  always_comb begin
    if (shr > SAT_HI) begin
      y_nxt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shr < SAT_LO) begin
      y_nxt = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_nxt = shr[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      x1_r   <= '0;
      x2_r   <= '0;
      y1_r   <= '0;
      y2_r   <= '0;
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= (i == 0) ? UNITY : '0;
      end
    end else begin
      done_r <= 1'b0;
      if (wr_here) begin
        case (ctrl.coef_index)
          COEF_B0: coef_r[0] <= coef_value;
          COEF_B1: coef_r[1] <= coef_value;
          COEF_B2: coef_r[2] <= coef_value;
          COEF_A1: coef_r[3] <= coef_value;
          COEF_A2: coef_r[4] <= coef_value;
          default: ;
        endcase
      end
      if (ctrl.clear) begin
        x1_r <= '0;
        x2_r <= '0;
        y1_r <= '0;
        y2_r <= '0;
      end
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        xin_r  <= x_in;
        acc_r  <= ROUND;
      end else if (busy_r) begin
        if (step_r < STEP_MAC) begin
          prod_r <= prod_nxt;
          sub_r  <= (step_r[CIDX_W-1:0] >= COEF_A1);
        end
        if (step_r != '0 && step_r <= STEP_MAC) begin
          acc_r <= acc_nxt;
        end
        if (step_r == STEP_LAST) begin
          // Round, saturate, shift history and hand the sample on
          y_r    <= y_nxt;
          x2_r   <= x1_r;
          x1_r   <= xin_r;
          y2_r   <= y1_r;
          y1_r   <= y_nxt;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign y_out = y_r;

endmodule

// ===== hdl/biquad_cascade_equalizer.sv =====
// Four-band biquad equalizer: a chain of direct form I section cells.
//
// Input channel in_ch carries items of three kinds. A sample item runs
// through every section in turn and gives one result on out_ch. A
// coefficient item writes one Q4.28 coefficient of one section and a clear
// item zeroes all section history; both take effect in the cycle they are
// accepted and give no result.
// Each section cell does five multiplies on its single multiplier, one per
// cycle, adds the last product, rounds and saturates, then hands the sample
// to its neighbor. in_ch stays low on ready from the acceptance of a sample
// until it is in the output register, so a new sample is not taken before
// the last one is through the chain. Coefficient and clear items go at one
// per cycle while no sample is in the chain.
// A finished sample waits in the output register while out_ch stalls; the
// next item is taken meanwhile. Should another sample finish before the
// first is taken, it is held in its last cell and in_ch waits.
// Reset sets each section to pass its input (b0 one, all else zero) and
// clears all history and the output register; in_ch is not ready in reset.
module biquad_cascade_equalizer #(
  parameter int SECTIONS    = bqe_pkg::SECTIONS_DEF,
  parameter int SAMPLE_BITS = bqe_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqe_pkg::COEF_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  bqe_in_if.sink    in_ch,
  bqe_out_if.source out_ch
);
  import bqe_pkg::*;

  logic                          accept, start0;
  cell_ctrl_t                    ctrl;
  logic                          done_w [SECTIONS];
  logic signed [SAMPLE_BITS-1:0] y_w    [SECTIONS];
  logic [SECTIONS-1:0]           done_vec;

  logic                          busy_r, pend_r, out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_free;

  assign in_ch.ready = rst_n && !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start0      = accept && (action_t'(in_ch.action) == ACT_FILTER);

  always_comb begin
    ctrl            = '0;
    ctrl.band       = in_ch.band;
    ctrl.coef_index = in_ch.coef_index;
    case (action_t'(in_ch.action))
      ACT_COEF:  ctrl.coef_wr = accept && (int'(in_ch.band) < SECTIONS)
                                       && (int'(in_ch.coef_index) < NCOEF);
      ACT_CLEAR: ctrl.clear   = accept;
      default:   ;
    endcase
  end

  for (genvar i = 0; i < SECTIONS; i++) begin : g_cell
    bqe_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .CELL_ID     (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .coef_value (in_ch.coef_value),
      .start      ((i == 0) ? start0 : done_w[(i == 0) ? 0 : i - 1]),
      .x_in       ((i == 0) ? in_ch.sample_in : y_w[(i == 0) ? 0 : i - 1]),
      .done       (done_w[i]),
      .y_out      (y_w[i])
    );
    assign done_vec[i] = done_w[i];
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_sample_r <= '0;
    end else begin
      if (start0) begin
        busy_r <= 1'b1;
      end
      if (done_w[SECTIONS-1] || pend_r) begin
        if (out_free) begin
          // Last cell keeps its output until the next sample starts
          out_sample_r <= y_w[SECTIONS-1];
          out_valid_r  <= 1'b1;
          pend_r       <= 1'b0;
          busy_r       <= 1'b0;
        end else begin
          pend_r <= 1'b1;
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

  a_one_cell_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec))
    else $error("more than one section finished in a cycle");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    done_w[SECTIONS-1] |-> !pend_r)
    else $error("sample finished while another was still held");

  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> busy_r)
    else $error("held sample without a busy chain");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start0 |=> busy_r && !in_ch.ready)
    else $error("chain not busy after a sample item");

endmodule
